// File: design/rsm_pkg.sv
// Shared types, constants and exponent tables for the row softmax block.
package rsm_pkg;

   // Width of the probability fraction before it is masked to the result field.
   localparam int SAMPLE_BITS = 16;
   // Quotient width: a probability of exactly one needs one bit more.
   localparam int QUOT_BITS = SAMPLE_BITS + 1;
   // Exponent values are unsigned Q1.16, at most 65536.
   localparam int EXP_BITS = 17;
   // Reset value of the running maximum.
   localparam logic [15:0] MOST_NEGATIVE = 16'h8000;
   // e^-1 in Q2.30.
   localparam logic [63:0] E_INV_Q30 = 64'd395007542;

   typedef logic [30:0] exp_neg_tab_type [32];
   typedef logic [31:0] series_tab_type [256];

   // Finished row handed from the loader to the evaluator.
   typedef struct packed {
      logic        bank;
      logic [15:0] maximum;
   } row_token_type;

   // Powers e^-k in Q2.30, each rounded from the previous one.
   function automatic exp_neg_tab_type build_exp_neg();
      exp_neg_tab_type tab;
      logic [63:0]     a;
      a = 64'd1 << 30;
      for (int k = 0; k < 32; k++) begin
         tab[k] = a[30:0];
         a = (a * E_INV_Q30 + (64'd1 << 29)) >> 30;
      end
      return tab;
   endfunction

   // Taylor series of e^(v/256) in Q2.30 with truncation after every term.
   function automatic logic [31:0] series_value(input logic [7:0] v);
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] vv;
      vv = 64'(v);
      term = 64'd1 << 30;
      s = term;
      term = (term * vv) / 64'd256;  s = s + term;
      term = (term * vv) / 64'd512;  s = s + term;
      term = (term * vv) / 64'd768;  s = s + term;
      term = (term * vv) / 64'd1024; s = s + term;
      term = (term * vv) / 64'd1280; s = s + term;
      term = (term * vv) / 64'd1536; s = s + term;
      term = (term * vv) / 64'd1792; s = s + term;
      term = (term * vv) / 64'd2048; s = s + term;
      term = (term * vv) / 64'd2304; s = s + term;
      term = (term * vv) / 64'd2560; s = s + term;
      term = (term * vv) / 64'd2816; s = s + term;
      term = (term * vv) / 64'd3072; s = s + term;
      term = (term * vv) / 64'd3328; s = s + term;
      return s[31:0];
   endfunction

   function automatic series_tab_type build_series();
      series_tab_type tab;
      for (int v = 0; v < 256; v++) begin
         tab[v] = series_value(8'(v));
      end
      return tab;
   endfunction

   localparam exp_neg_tab_type EXP_NEG_TAB = build_exp_neg();
   localparam series_tab_type  SERIES_TAB  = build_series();

endpackage

// File: design/rsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rsm_front.sv
// Loader: saturates incoming pairs, stores them and tracks the row maximum.
module rsm_front #(
   parameter int PAIRS_PER_ROW = 32,
   parameter int IDX_BITS      = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_first_value,
   input  logic [15:0]            req_second_value,
   input  logic [15:0]            req_first_extra,
   input  logic [15:0]            req_second_extra,
   output logic                   wr_en,
   output logic [IDX_BITS:0]      wr_addr,
   output logic [31:0]            wr_data,
   output logic                   push,
   output rsm_pkg::row_token_type push_token,
   input  logic                   queue_full
);

   logic [IDX_BITS-1:0] count_ff, count_in;
   logic [15:0]         max_ff, max_in;
   logic                bank_ff, bank_in;
   logic                accept;
   logic                last_pair;
   logic [15:0]         x0, x1, max_a, max_b;

   // Sum of two Q8.8 values clamped to the Q8.8 range.
   function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {a[15], a} + {b[15], b};
      if (s[16] != s[15]) begin
         return s[16] ? 16'h8000 : 16'h7fff;
      end
      return s[15:0];
   endfunction

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;
   assign last_pair = (count_ff == IDX_BITS'(PAIRS_PER_ROW - 1));

   assign x0    = sat_sum(req_first_value, req_first_extra);
   assign x1    = sat_sum(req_second_value, req_second_extra);
   assign max_a = ($signed(x0) > $signed(max_ff)) ? x0 : max_ff;
   assign max_b = ($signed(x1) > $signed(max_a)) ? x1 : max_a;

   assign wr_en   = accept;
   assign wr_addr = {bank_ff, count_ff};
   assign wr_data = {x1, x0};

   // A completed row is handed over with its bank and maximum.
   assign push               = accept & last_pair;
   assign push_token.bank    = bank_ff;
   assign push_token.maximum = max_b;

   // Row position, maximum and bank selection.
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (last_pair) begin
            count_in = '0;
            max_in   = rsm_pkg::MOST_NEGATIVE;
            bank_in  = ~bank_ff;
         end else begin
            count_in = count_ff + 1'b1;
            max_in   = max_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= rsm_pkg::MOST_NEGATIVE;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

// File: design/rsm_queue.sv
// Two-entry queue of finished rows between the loader and the evaluator.
module rsm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsm_pkg::row_token_type push_token,
   input  logic                   pop,
   output rsm_pkg::row_token_type head,
   output logic                   empty,
   output logic                   full
);

   rsm_pkg::row_token_type entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// File: design/rsm_div.sv
// Restoring divider: rounded probability (e * 2^SAMPLE_BITS + S/2) / S, one bit per cycle.
module rsm_div #(
   parameter int SUM_BITS = 23
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rsm_pkg::EXP_BITS-1:0]   e,
   input  logic [SUM_BITS-1:0]            sum,
   output logic                           busy,
   output logic [rsm_pkg::QUOT_BITS-1:0]  quotient
);

   localparam int QB = rsm_pkg::QUOT_BITS;
   localparam int NW = SUM_BITS + QB;
   localparam int CW = $clog2(QB + 1);

   logic [SUM_BITS-1:0] rem_ff, rem_in;
   logic [QB-1:0]       low_ff, low_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                busy_ff, busy_in;
   logic [NW-1:0]       numer;
   logic [SUM_BITS:0]   trial;
   logic                fits;

   // The quotient stays below 2^QUOT_BITS, so the upper part starts below S.
   assign numer = (NW'(e) << rsm_pkg::SAMPLE_BITS) + NW'(sum >> 1);
   assign trial = {rem_ff, low_ff[QB-1]};
   assign fits  = (trial >= {1'b0, sum});

   // One quotient bit per cycle.
   always_comb begin
      rem_in   = rem_ff;
      low_in   = low_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = numer[NW-1:QB];
         low_in   = numer[QB-1:0];
         count_in = CW'(QB);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? SUM_BITS'(trial - {1'b0, sum}) : trial[SUM_BITS-1:0];
         low_in   = {low_ff[QB-2:0], fits};
         count_in = count_ff - 1'b1;
         busy_in  = (count_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign busy     = busy_ff;
   assign quotient = low_ff;

endmodule

// File: design/rsm_back.sv
// Evaluator: exponent and sum pass over a stored row, then normalized result pairs.
module rsm_back #(
   parameter int PAIRS_PER_ROW = 32,
   parameter int IDX_BITS      = 5,
   parameter int SUM_BITS      = 23
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsm_pkg::row_token_type head,
   input  logic                   queue_empty,
   output logic                   queue_pop,
   output logic [IDX_BITS:0]      rd_addr,
   input  logic [31:0]            rd_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [15:0]            rsp_first_probability,
   output logic [15:0]            rsp_second_probability,
   output logic                   rsp_last_of_row
);

   localparam int QB = rsm_pkg::QUOT_BITS;
   localparam int SB = rsm_pkg::SAMPLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_LOOK, ST_MUL, ST_ROUND, ST_USE, ST_DIV, ST_OUT
   } state_type;

   typedef struct packed {
      logic [30:0] scale;
      logic [31:0] series;
   } exp_parts_type;

   state_type                     state_ff, state_in;
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic                          pass_ff, pass_in;
   logic [SUM_BITS-1:0]           sum_ff, sum_in;
   exp_parts_type                 parts0_ff, parts0_in, parts1_ff, parts1_in;
   logic [62:0]                   prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic [rsm_pkg::EXP_BITS-1:0]  e0_ff, e0_in, e1_ff, e1_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   prob0_ff, prob0_in, prob1_ff, prob1_in;
   logic                          last_ff, last_in;
   logic                          last_idx;
   logic                          div_start;
   logic                          busy0, busy1;
   logic [QB-1:0]                 quot0, quot1;

   // Splits t = x - max into e^-k and e^(v/256) factors; zero scale below -16.0.
   function automatic exp_parts_type split_exponent(input logic [15:0] x,
                                                    input logic [15:0] mx);
      logic signed [16:0] t;
      logic [16:0]        m;
      logic [7:0]         f;
      logic [4:0]         k;
      logic [7:0]         v;
      logic               far;
      exp_parts_type      r;
      t   = $signed({x[15], x}) - $signed({mx[15], mx});
      m   = 17'(-t);
      far = (t < -17'sd4096);
      f   = m[7:0];
      k   = m[12:8] + 5'(f != 8'd0);
      v   = 8'(9'd256 - {1'b0, f});
      r.scale  = far ? 31'd0 : rsm_pkg::EXP_NEG_TAB[k];
      r.series = rsm_pkg::SERIES_TAB[v];
      return r;
   endfunction

   // Two rounding steps from the Q4.60 product down to Q1.16.
   function automatic logic [rsm_pkg::EXP_BITS-1:0] round_exp(input logic [62:0] p);
      logic [62:0] rs;
      logic [33:0] r2;
      rs = p + (63'd1 << 29);
      r2 = {1'b0, rs[62:30]} + 34'd8192;
      return r2[30:14];
   endfunction

   // Probability saturated to the sample range and cut to the field.
   function automatic logic [15:0] cap_prob(input logic [QB-1:0] q);
      logic [SB-1:0] p;
      p = q[QB-1] ? {SB{1'b1}} : q[SB-1:0];
      return 16'(p);
   endfunction

   assign last_idx  = (idx_ff == IDX_BITS'(PAIRS_PER_ROW - 1));
   assign rd_addr   = {head.bank, idx_ff};
   assign div_start = (state_ff == ST_USE) && pass_ff;
   assign queue_pop = (state_ff == ST_OUT) && !rsp_stall && last_idx;

   rsm_div #(.SUM_BITS(SUM_BITS)) u_div0 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .e        (e0_ff),
      .sum      (sum_ff),
      .busy     (busy0),
      .quotient (quot0)
   );

   rsm_div #(.SUM_BITS(SUM_BITS)) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .e        (e1_ff),
      .sum      (sum_ff),
      .busy     (busy1),
      .quotient (quot1)
   );

   // Sequencer: sum pass over the row, then one divide and transfer per pair.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      sum_in       = sum_ff;
      parts0_in    = parts0_ff;
      parts1_in    = parts1_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      rsp_valid_in = rsp_valid_ff;
      prob0_in     = prob0_ff;
      prob1_in     = prob1_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               idx_in   = '0;
               pass_in  = 1'b0;
               sum_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            parts0_in = split_exponent(rd_data[15:0], head.maximum);
            parts1_in = split_exponent(rd_data[31:16], head.maximum);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod0_in = 63'(parts0_ff.scale) * 63'(parts0_ff.series);
            prod1_in = 63'(parts1_ff.scale) * 63'(parts1_ff.series);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            e0_in    = round_exp(prod0_ff);
            e1_in    = round_exp(prod1_ff);
            state_in = ST_USE;
         end
         ST_USE: begin
            if (pass_ff) begin
               state_in = ST_DIV;
            end else begin
               sum_in = sum_ff + SUM_BITS'(e0_ff) + SUM_BITS'(e1_ff);
               if (last_idx) begin
                  pass_in = 1'b1;
                  idx_in  = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (!busy0 && !busy1) begin
               prob0_in     = cap_prob(quot0);
               prob1_in     = cap_prob(quot1);
               last_in      = last_idx;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
      end
      sum_ff    <= sum_in;
      parts0_ff <= parts0_in;
      parts1_ff <= parts1_in;
      prod0_ff  <= prod0_in;
      prod1_ff  <= prod1_in;
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      prob0_ff  <= prob0_in;
      prob1_ff  <= prob1_in;
      last_ff   <= last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_first_probability  = prob0_ff;
   assign rsp_second_probability = prob1_ff;
   assign rsp_last_of_row        = last_ff;

   // A result is only offered from the transfer state.
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT)
      else $error("result offered outside the transfer state");

   // A row is retired only while one is queued.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("row retired from an empty queue");

   // The maximum element alone contributes 1.0, so the divisor is at least that.
   a_sum_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> sum_ff >= SUM_BITS'(65536))
      else $error("exponent sum below one");

   // A probability never exceeds one before saturation.
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !busy0) |-> quot0 <= QB'(1 << SB))
      else $error("probability quotient above one");

endmodule

// File: design/row_softmax_64_top.sv
// Top level of the streaming row softmax block.
// Each transfer on the req channel carries two adjacent row elements and their addends;
// after PAIRS_PER_ROW transfers the row is complete and PAIRS_PER_ROW result pairs
// follow on the rsp channel, the last one flagged with rsp_last_of_row. Pairs load at
// one per cycle into one of two RAM banks, so the next row loads while the previous one
// is evaluated; only when two finished rows wait does req_stall rise. Evaluation of a
// row is serial in the back end: an exponent and sum pass over every pair (read, look-up,
// multiply, round, accumulate), then for each result pair the exponent again, the
// 17-step bit-serial divider and the transfer, which is held while rsp_stall is high.
module row_softmax_64_top #(
   parameter int PAIRS_PER_ROW = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_first_value,
   input  logic [15:0] req_second_value,
   input  logic [15:0] req_first_extra,
   input  logic [15:0] req_second_extra,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_first_probability,
   output logic [15:0] rsp_second_probability,
   output logic        rsp_last_of_row
);

   localparam int IDX_BITS  = (PAIRS_PER_ROW > 1) ? $clog2(PAIRS_PER_ROW) : 1;
   localparam int ADDR_BITS = IDX_BITS + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_BITS;
   localparam int SUM_BITS  = $clog2(2 * PAIRS_PER_ROW) + rsm_pkg::EXP_BITS;

   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [31:0]            wr_data;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [31:0]            rd_data;
   logic                   push;
   logic                   pop;
   logic                   queue_empty;
   logic                   queue_full;
   rsm_pkg::row_token_type push_token;
   rsm_pkg::row_token_type head;

   rsm_front #(
      .PAIRS_PER_ROW (PAIRS_PER_ROW),
      .IDX_BITS      (IDX_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .req_first_extra  (req_first_extra),
      .req_second_extra (req_second_extra),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .push             (push),
      .push_token       (push_token),
      .queue_full       (queue_full)
   );

   rsm_ram #(
      .WIDTH (32),
      .DEPTH (RAM_DEPTH)
   ) u_pair_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   rsm_back #(
      .PAIRS_PER_ROW (PAIRS_PER_ROW),
      .IDX_BITS      (IDX_BITS),
      .SUM_BITS      (SUM_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (head),
      .queue_empty            (queue_empty),
      .queue_pop              (pop),
      .rd_addr                (rd_addr),
      .rd_data                (rd_data),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_first_probability  (rsp_first_probability),
      .rsp_second_probability (rsp_second_probability),
      .rsp_last_of_row        (rsp_last_of_row)
   );

endmodule
